[rtl/lrm_pkg.sv]
// Package for the label region mean block: field widths, defaults and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lrm_pkg;

	localparam int CFG_W   = 6;
	localparam int LABEL_W = 8;
	localparam int PIX_W   = 8;
	localparam int IDX_W   = 6;
	localparam int MEAN_W  = 16;
	localparam int FRAC_W  = 8;
	localparam int TOTAL_W = 28;
	localparam int COUNT_W = 21;

	localparam int MAX_LABELS_DEF = 32;
	localparam int MAX_PIXELS_DEF = 1048576;

	localparam logic [CFG_W-1:0]  SEED_RESET = CFG_W'(1);
	localparam logic [MEAN_W-1:0] MEAN_MAX   = 16'hFF00;

	typedef struct packed {
		logic capture;
		logic acc_wr;
		logic rd_report;
		logic div_start;
		logic load_out;
		logic clear_all;
	} lrm_cmd_t;

	typedef struct packed {
		logic last_s1;
		logic n_zero;
		logic div_busy;
		logic out_free;
		logic rep_last;
	} lrm_sts_t;

endpackage

`default_nettype wire

[rtl/lrm_pix_if.sv]
// Pixel channel: valid/ready handshake with label, intensity and last flag.
// Depends on lrm_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lrm_pix_if;
	import lrm_pkg::*;

	logic               valid;
	logic               ready;
	logic [LABEL_W-1:0] region_label;
	logic [PIX_W-1:0]   intensity;
	logic               last_pixel;

	modport source (output valid, output region_label, output intensity, output last_pixel,
		input ready);
	modport sink (input valid, input region_label, input intensity, input last_pixel,
		output ready);
endinterface

`default_nettype wire

[rtl/lrm_res_if.sv]
// Result channel: valid/ready handshake carrying one per-label report beat.
// Depends on lrm_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lrm_res_if;
	import lrm_pkg::*;

	logic               valid;
	logic               ready;
	logic [IDX_W-1:0]   label_index;
	logic [MEAN_W-1:0]  mean_fixed;
	logic [TOTAL_W-1:0] intensity_total;
	logic [COUNT_W-1:0] pixel_count;
	logic               empty_region;
	logic               last_label;

	modport source (output valid, output label_index, output mean_fixed,
		output intensity_total, output pixel_count, output empty_region, output last_label,
		input ready);
	modport sink (input valid, input label_index, input mean_fixed,
		input intensity_total, input pixel_count, input empty_region, input last_label,
		output ready);
endinterface

`default_nettype wire

[rtl/lrm_div.sv]
// Restoring divider, one quotient bit per cycle: (sum << 8) / count.
// Depends on lrm_pkg. Expects the quotient to fit MEAN_W bits.
`timescale 1ns / 1ps
`default_nettype none

module lrm_div #(
	parameter int CW = 21
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [CW+lrm_pkg::PIX_W-1:0]   sum,
	input  wire logic [CW-1:0]                  divisor,
	output logic                                busy,
	output logic [lrm_pkg::MEAN_W-1:0]          quot
);
	import lrm_pkg::*;

	localparam int SW  = CW + PIX_W;
	localparam int LW  = MEAN_W - FRAC_W;
	localparam int STW = $clog2(MEAN_W + 1);

	logic [CW-1:0]     rem_q;
	logic [MEAN_W-1:0] lo_q;
	logic [MEAN_W-1:0] q_q;
	logic [CW-1:0]     dvs_q;
	logic [STW-1:0]    step_q;
	logic              busy_q;

	logic [CW:0]       trial;
	logic [CW:0]       diff;
	logic              ge;

	assign trial = {rem_q, lo_q[MEAN_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + STW'(1);
			if (step_q == STW'(MEAN_W - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= sum[SW-1:LW];
			lo_q  <= {sum[LW-1:0], {FRAC_W{1'b0}}};
			dvs_q <= divisor;
			q_q   <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[CW-1:0] : trial[CW-1:0];
			lo_q  <= {lo_q[MEAN_W-2:0], 1'b0};
			q_q   <= {q_q[MEAN_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = q_q;

endmodule

`default_nettype wire

[rtl/lrm_dpath.sv]
// Datapath: seed count register, accumulator memory with valid bits,
// read-modify-write, divider and the result output register.
// Depends on lrm_pkg and lrm_div.
`timescale 1ns / 1ps
`default_nettype none

module lrm_dpath #(
	parameter int MAX_LABELS = lrm_pkg::MAX_LABELS_DEF,
	parameter int MAX_PIXELS = lrm_pkg::MAX_PIXELS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [lrm_pkg::CFG_W-1:0]     cfg_wdata,
	input  wire logic [lrm_pkg::LABEL_W-1:0]   region_label,
	input  wire logic [lrm_pkg::PIX_W-1:0]     intensity,
	input  wire logic                          last_pixel,
	input  wire lrm_pkg::lrm_cmd_t             cmd,
	output lrm_pkg::lrm_sts_t                  sts,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [lrm_pkg::IDX_W-1:0]          label_index,
	output logic [lrm_pkg::MEAN_W-1:0]         mean_fixed,
	output logic [lrm_pkg::TOTAL_W-1:0]        intensity_total,
	output logic [lrm_pkg::COUNT_W-1:0]        pixel_count,
	output logic                               empty_region,
	output logic                               last_label
);
	import lrm_pkg::*;

	localparam int AW = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
	localparam int NW = $clog2(MAX_LABELS + 1);
	localparam int CW = $clog2(MAX_PIXELS + 1);
	localparam int SW = CW + PIX_W;

	typedef struct packed {
		logic [SW-1:0] sum;
		logic [CW-1:0] cnt;
	} entry_t;

	logic [CFG_W-1:0]      seed_q;
	logic [NW-1:0]         n_eff;
	logic [NW-1:0]         n_q;
	logic [NW-1:0]         k_q;
	logic [AW-1:0]         slot_in;
	logic [AW-1:0]         rd_addr;
	logic [AW-1:0]         slot_s1;
	logic [PIX_W-1:0]      pix_s1;
	logic                  hit_s1;
	logic                  last_s1;

	entry_t                mem [MAX_LABELS];
	entry_t                rdata_q;
	logic                  rvld_q;
	logic [MAX_LABELS-1:0] vld_q;
	entry_t                ent;
	entry_t                ent_next;
	logic                  sat;
	logic                  acc_do;
	logic                  rep_last;
	logic                  hit_in;

	logic                  div_busy;
	logic [MEAN_W-1:0]     quot;

	assign n_eff   = (int'(seed_q) > MAX_LABELS) ? NW'(MAX_LABELS) : NW'(seed_q);
	assign hit_in  = (region_label != '0) && (int'(region_label) <= int'(n_eff));
	assign slot_in = AW'(region_label - LABEL_W'(1));
	assign rd_addr = cmd.rd_report ? k_q[AW-1:0] : slot_in;

	assign ent          = rvld_q ? rdata_q : '0;
	assign sat          = ent.cnt >= CW'(MAX_PIXELS);
	assign ent_next.sum = ent.sum + SW'(pix_s1);
	assign ent_next.cnt = ent.cnt + CW'(1);
	assign acc_do       = cmd.acc_wr && hit_s1 && !sat;
	assign rep_last     = (k_q + NW'(1)) == n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
		end else if (cfg_we) begin
			seed_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			slot_s1 <= slot_in;
			pix_s1  <= intensity;
			hit_s1  <= hit_in;
			last_s1 <= last_pixel;
			n_q     <= n_eff;
		end
	end

	// accumulator memory, one write and one read port
	always_ff @(posedge clk) begin
		if (acc_do)
			mem[slot_s1] <= ent_next;
		if (cmd.capture || cmd.rd_report)
			rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
			k_q    <= '0;
		end else begin
			if (cmd.capture || cmd.rd_report)
				rvld_q <= vld_q[rd_addr];
			if (cmd.clear_all) begin
				vld_q <= '0;
				k_q   <= '0;
			end else begin
				if (acc_do)
					vld_q[slot_s1] <= 1'b1;
				if (cmd.load_out)
					k_q <= k_q + NW'(1);
			end
		end
	end

	lrm_div #(
		.CW(CW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.sum     (ent.sum),
		.divisor (ent.cnt),
		.busy    (div_busy),
		.quot    (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			label_index     <= IDX_W'(k_q + NW'(1));
			mean_fixed      <= (ent.cnt == '0) ? '0 : quot;
			intensity_total <= TOTAL_W'(ent.sum);
			pixel_count     <= COUNT_W'(ent.cnt);
			empty_region    <= ent.cnt == '0;
			last_label      <= rep_last;
		end
	end

	assign sts.last_s1  = last_s1;
	assign sts.n_zero   = n_q == '0;
	assign sts.div_busy = div_busy;
	assign sts.out_free = !out_valid || out_ready;
	assign sts.rep_last = rep_last;

endmodule

`default_nettype wire

[rtl/lrm_ctrl.sv]
// Controller: sequences pixel read-modify-write and the per-label report.
// Depends on lrm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrm_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output lrm_pkg::lrm_cmd_t      cmd,
	input  wire lrm_pkg::lrm_sts_t sts
);
	import lrm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ACC,
		S_RD,
		S_DIV,
		S_WAIT,
		S_EMIT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_ACC;
				end
				S_ACC: begin
					if (!sts.last_s1 || sts.n_zero)
						state_q <= S_IDLE;
					else
						state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (!sts.div_busy)
						state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (sts.out_free)
						state_q <= sts.rep_last ? S_IDLE : S_RD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		cmd           = '0;
		cmd.capture   = (state_q == S_IDLE) && in_valid;
		cmd.acc_wr    = state_q == S_ACC;
		cmd.rd_report = state_q == S_RD;
		cmd.div_start = state_q == S_DIV;
		cmd.load_out  = (state_q == S_EMIT) && sts.out_free;
		cmd.clear_all = ((state_q == S_ACC) && sts.last_s1 && sts.n_zero)
			|| ((state_q == S_EMIT) && sts.out_free && sts.rep_last);
	end

endmodule

`default_nettype wire

[rtl/label_region_mean.sv]
// Top level: per-label intensity sum/count with a mean report on the last pixel.
// Depends on lrm_pkg, lrm_pix_if, lrm_res_if, lrm_ctrl, lrm_dpath.
//
//   channel  dir  handshake      payload
//   pix      in   valid/ready    region_label, intensity, last_pixel
//   res      out  valid/ready    label_index, mean_fixed, intensity_total,
//                                pixel_count, empty_region, last_label
//   cfg      in   cfg_we         cfg_wdata (seed_count)
//
// A pixel beat is an accumulator memory read, then add and write back.
// A report is, per label, a memory read, a divider run and an output load.
// Reset clears the seed count to 1 and the per-entry valid bits; no clearing sweep.
// The valid bits drop at once after each report.
// A stalled result holds in the output register; pixels resume after the last.
`timescale 1ns / 1ps
`default_nettype none

module label_region_mean #(
	parameter int MAX_LABELS = lrm_pkg::MAX_LABELS_DEF,
	parameter int MAX_PIXELS = lrm_pkg::MAX_PIXELS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [lrm_pkg::CFG_W-1:0] cfg_wdata,
	lrm_pix_if.sink                        pix,
	lrm_res_if.source                      res
);
	import lrm_pkg::*;

	lrm_cmd_t cmd;
	lrm_sts_t sts;
	logic     in_ready;

	assign pix.ready = in_ready;

	lrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pix.valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	lrm_dpath #(
		.MAX_LABELS(MAX_LABELS),
		.MAX_PIXELS(MAX_PIXELS)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.region_label    (pix.region_label),
		.intensity       (pix.intensity),
		.last_pixel      (pix.last_pixel),
		.cmd             (cmd),
		.sts             (sts),
		.out_valid       (res.valid),
		.out_ready       (res.ready),
		.label_index     (res.label_index),
		.mean_fixed      (res.mean_fixed),
		.intensity_total (res.intensity_total),
		.pixel_count     (res.pixel_count),
		.empty_region    (res.empty_region),
		.last_label      (res.last_label)
	);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!res.valid || res.ready))
		else $error("result register overwritten while pending");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.empty_region) |->
			(res.mean_fixed == '0 && res.pixel_count == '0 && res.intensity_total == '0))
		else $error("empty region with nonzero fields");

	a_mean_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.mean_fixed <= MEAN_MAX))
		else $error("mean out of range");

	a_no_accept_in_report: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_report || cmd.div_start || sts.div_busy) |-> !pix.ready)
		else $error("pixel accepted during report");

endmodule

`default_nettype wire

[test/tb_label_region_mean.sv]
// Testbench for label_region_mean: a table of directed pixels and seed writes, then random images
// mostly under random stalls, with each report beat checked against a typed table report or
// a per-label sum/count shadow. Depends on lrm_pkg, lrm_pix_if, lrm_res_if and the label_region_mean RTL.
`timescale 1ns / 1ps

module tb_label_region_mean;
	import lrm_pkg::*;

	typedef struct packed {
		logic [IDX_W-1:0]   label_index;
		logic [MEAN_W-1:0]  mean_fixed;
		logic [TOTAL_W-1:0] intensity_total;
		logic [COUNT_W-1:0] pixel_count;
		logic               empty_region;
		logic               last_label;
	} report_t;

	typedef enum logic {ROW_PIXEL, ROW_CONFIG} row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		logic [CFG_W-1:0]   seed;
		logic [LABEL_W-1:0] region_label;
		logic [PIX_W-1:0]   intensity;
		logic               last_pixel;
		logic               typed;
		report_t            report;
	} row_t;

	localparam int SETTLE_CYCLES = 10;
	localparam int RANDOM_PIXELS = 420;
	localparam int LONG_HOLD     = 600;

	localparam report_t NO_REPORT = '0;
	localparam report_t EMPTY_ONE = '{6'd1, 16'd0, 28'd0, 21'd0, 1'b1, 1'b1};

	localparam int N_ROWS = 26;
	localparam row_t PLAN [N_ROWS] = '{
		'{ROW_PIXEL,  6'd0,  8'd1,   8'd255, 1'b1, 1'b1,
			'{6'd1, 16'hFF00, 28'd255, 21'd1, 1'b0, 1'b1}},
		'{ROW_PIXEL,  6'd0,  8'd0,   8'd7,   1'b1, 1'b1, EMPTY_ONE},
		'{ROW_PIXEL,  6'd0,  8'd2,   8'd100, 1'b1, 1'b1, EMPTY_ONE},
		'{ROW_PIXEL,  6'd0,  8'd1,   8'd0,   1'b0, 1'b0, NO_REPORT},
		'{ROW_PIXEL,  6'd0,  8'd1,   8'd255, 1'b0, 1'b0, NO_REPORT},
		'{ROW_PIXEL,  6'd0,  8'd1,   8'd255, 1'b1, 1'b1,
			'{6'd1, 16'hAA00, 28'd510, 21'd3, 1'b0, 1'b1}},
		'{ROW_PIXEL,  6'd0,  8'd1,   8'd50,  1'b0, 1'b0, NO_REPORT},
		'{ROW_CONFIG, 6'd0,  8'd0,   8'd0,   1'b0, 1'b0, NO_REPORT},
		'{ROW_PIXEL,  6'd0,  8'd1,   8'd9,   1'b1, 1'b0, NO_REPORT},
		'{ROW_CONFIG, 6'd1,  8'd0,   8'd0,   1'b0, 1'b0, NO_REPORT},
		'{ROW_PIXEL,  6'd0,  8'd0,   8'd0,   1'b1, 1'b1, EMPTY_ONE},
		'{ROW_CONFIG, 6'd63, 8'd0,   8'd0,   1'b0, 1'b0, NO_REPORT},
		'{ROW_PIXEL,  6'd0,  8'd32,  8'd255, 1'b0, 1'b0, NO_REPORT},
		'{ROW_PIXEL,  6'd0,  8'd33,  8'd1,   1'b0, 1'b0, NO_REPORT},
		'{ROW_PIXEL,  6'd0,  8'd255, 8'd255, 1'b0, 1'b0, NO_REPORT},
		'{ROW_PIXEL,  6'd0,  8'd31,  8'd1,   1'b1, 1'b0, NO_REPORT},
		'{ROW_CONFIG, 6'd32, 8'd0,   8'd0,   1'b0, 1'b0, NO_REPORT},
		'{ROW_PIXEL,  6'd0,  8'd32,  8'd128, 1'b0, 1'b0, NO_REPORT},
		'{ROW_PIXEL,  6'd0,  8'd16,  8'd3,   1'b1, 1'b0, NO_REPORT},
		'{ROW_CONFIG, 6'd2,  8'd0,   8'd0,   1'b0, 1'b0, NO_REPORT},
		'{ROW_PIXEL,  6'd0,  8'd2,   8'd10,  1'b0, 1'b0, NO_REPORT},
		'{ROW_CONFIG, 6'd1,  8'd0,   8'd0,   1'b0, 1'b0, NO_REPORT},
		'{ROW_PIXEL,  6'd0,  8'd2,   8'd20,  1'b0, 1'b0, NO_REPORT},
		'{ROW_PIXEL,  6'd0,  8'd1,   8'd5,   1'b1, 1'b1,
			'{6'd1, 16'h0500, 28'd5, 21'd1, 1'b0, 1'b1}},
		'{ROW_CONFIG, 6'd2,  8'd0,   8'd0,   1'b0, 1'b0, NO_REPORT},
		'{ROW_PIXEL,  6'd0,  8'd0,   8'd0,   1'b1, 1'b0, NO_REPORT}
	};

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	lrm_pix_if pix_bus();
	lrm_res_if res_bus();

	label_region_mean dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pix       (pix_bus),
		.res       (res_bus)
	);

	// shadow of the block's accumulators
	logic [CFG_W-1:0]   seed_shadow;
	logic [TOTAL_W-1:0] sum_shadow   [MAX_LABELS_DEF];
	logic [COUNT_W-1:0] count_shadow [MAX_LABELS_DEF];

	report_t report_batch[$];
	report_t label_reports_due[$];

	int  errors;
	int  beats_seen;
	bit  no_gaps;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic void tally_pixel(logic [LABEL_W-1:0] lbl, logic [PIX_W-1:0] level,
		logic last);
		int          n;
		int          k;
		logic [63:0] num;
		report_t     r;
		n = (seed_shadow > MAX_LABELS_DEF) ? MAX_LABELS_DEF : int'(seed_shadow);
		report_batch.delete();
		if (lbl >= 1 && int'(lbl) <= n) begin
			if (count_shadow[lbl-1] < MAX_PIXELS_DEF) begin
				count_shadow[lbl-1] = count_shadow[lbl-1] + 1'b1;
				sum_shadow[lbl-1]   = sum_shadow[lbl-1] + TOTAL_W'(level);
			end
		end
		if (last) begin
			for (k = 0; k < n; k++) begin
				num = 64'(sum_shadow[k]) << FRAC_W;
				r.label_index     = IDX_W'(k + 1);
				r.mean_fixed      = (count_shadow[k] == 0) ? '0 :
					MEAN_W'(num / 64'(count_shadow[k]));
				r.intensity_total = sum_shadow[k];
				r.pixel_count     = count_shadow[k];
				r.empty_region    = (count_shadow[k] == 0);
				r.last_label      = (k + 1 == n);
				report_batch.push_back(r);
			end
			for (k = 0; k < MAX_LABELS_DEF; k++) begin
				sum_shadow[k]   = '0;
				count_shadow[k] = '0;
			end
		end
	endfunction

	// one pixel beat; called and returns at a falling edge
	task automatic drive_pixel(input row_t row);
		while (!no_gaps && $urandom_range(0, 99) < 19) begin
			pix_bus.valid <= 1'b0;
			@(negedge clk);
		end
		pix_bus.valid        <= 1'b1;
		pix_bus.region_label <= row.region_label;
		pix_bus.intensity    <= row.intensity;
		pix_bus.last_pixel   <= row.last_pixel;
		do @(posedge clk); while (!pix_bus.ready);
		tally_pixel(row.region_label, row.intensity, row.last_pixel);
		if (row.typed)
			label_reports_due.push_back(row.report);
		else
			foreach (report_batch[i]) label_reports_due.push_back(report_batch[i]);
		@(negedge clk);
	endtask

	task automatic settle();
		pix_bus.valid <= 1'b0;
		while (label_reports_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_seed(input logic [CFG_W-1:0] v);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we      <= 1'b0;
		seed_shadow  = v;
	endtask

	function automatic logic [CFG_W-1:0] pick_seed();
		case ($urandom_range(0, 9))
			0: pick_seed = 6'd0;
			1: pick_seed = 6'd63;
			2: pick_seed = CFG_W'($urandom_range(33, 63));
			3: pick_seed = 6'd32;
			4: pick_seed = 6'd1;
			5: pick_seed = CFG_W'($urandom_range(7, 32));
			default: pick_seed = CFG_W'($urandom_range(1, 6));
		endcase
	endfunction

	// result sink: random stalls (none while no_gaps is set) plus one long hold-off
	initial begin
		bit held;
		held = 1'b0;
		res_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && beats_seen >= 150) begin
				held = 1'b1;
				res_bus.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end
			res_bus.ready <= no_gaps || ($urandom_range(0, 99) >= 19);
		end
	end

	always @(posedge clk) begin
		report_t got;
		report_t want;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			got = '{res_bus.label_index, res_bus.mean_fixed, res_bus.intensity_total,
				res_bus.pixel_count, res_bus.empty_region, res_bus.last_label};
			beats_seen++;
			if (label_reports_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected report beat, label %0d mean %h total %0d count %0d",
					$time, got.label_index, got.mean_fixed, got.intensity_total,
					got.pixel_count);
			end else begin
				want = label_reports_due.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t: report mismatch: expected label %0d mean %h total %0d",
						$time, want.label_index, want.mean_fixed, want.intensity_total,
						" count %0d empty %b last %b", want.pixel_count, want.empty_region,
						want.last_label);
					$display("%0t:                  actual label %0d mean %h total %0d",
						$time, got.label_index, got.mean_fixed, got.intensity_total,
						" count %0d empty %b last %b", got.pixel_count, got.empty_region,
						got.last_label);
				end
			end
		end
	end

	initial begin
		#50_000_000;
		$display("tb_label_region_mean: FAIL");
		$finish;
	end

	initial begin
		row_t row;
		int   img;
		int   len;
		int   n;
		int   sent;
		int   p;
		errors               = 0;
		beats_seen           = 0;
		no_gaps              = 1'b0;
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_wdata            = '0;
		pix_bus.valid        = 1'b0;
		pix_bus.region_label = '0;
		pix_bus.intensity    = '0;
		pix_bus.last_pixel   = 1'b0;
		seed_shadow          = SEED_RESET;
		for (p = 0; p < MAX_LABELS_DEF; p++) begin
			sum_shadow[p]   = '0;
			count_shadow[p] = '0;
		end
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (p = 0; p < N_ROWS; p++) begin
			if (PLAN[p].kind == ROW_CONFIG)
				write_seed(PLAN[p].seed);
			else
				drive_pixel(PLAN[p]);
		end

		sent = 0;
		img  = 0;
		while (sent < RANDOM_PIXELS) begin
			no_gaps = (img >= 12 && img < 20);
			if (img == 25)
				settle();
			if ($urandom_range(0, 99) < 30)
				write_seed(pick_seed());
			len = ($urandom_range(0, 99) < 5) ? 60 : $urandom_range(1, 16);
			for (int i = 0; i < len; i++) begin
				if (i != 0 && $urandom_range(0, 99) < 4)
					write_seed(pick_seed());
				n = (seed_shadow > MAX_LABELS_DEF) ? MAX_LABELS_DEF : int'(seed_shadow);
				row = '0;
				row.kind = ROW_PIXEL;
				if (n > 0 && $urandom_range(0, 99) < 85)
					row.region_label = LABEL_W'($urandom_range(1, n));
				else
					row.region_label = LABEL_W'($urandom_range(0, 255));
				case ($urandom_range(0, 9))
					0: row.intensity = '0;
					1: row.intensity = '1;
					default: row.intensity = PIX_W'($urandom);
				endcase
				row.last_pixel = (i == len - 1);
				drive_pixel(row);
				sent++;
			end
			img++;
		end
		no_gaps = 1'b0;

		settle();
		repeat (90) @(negedge clk);
		if (errors == 0 && label_reports_due.size() == 0)
			$display("tb_label_region_mean: PASS");
		else
			$display("tb_label_region_mean: FAIL");
		$finish;
	end

endmodule

[filelist.f]
rtl/lrm_pkg.sv
rtl/lrm_pix_if.sv
rtl/lrm_res_if.sv
rtl/lrm_div.sv
rtl/lrm_dpath.sv
rtl/lrm_ctrl.sv
rtl/label_region_mean.sv
test/tb_label_region_mean.sv
